/* rtl/tdrp_pkg.sv */
// ----------------------------------------------------------------------------
// tdrp_pkg
// Shared types, constants and helpers of the temperature delta record packer.
// ----------------------------------------------------------------------------
package tdrp_pkg;

  localparam int ENTRIES_PER_RECORD = 8;
  localparam int RECORD_STRIDE      = 36;
  localparam int RECORDS_PER_PAGE   = 28;
  localparam int PAGE_BYTES         = 1024;

  localparam int HEADER_BYTES = 8;
  localparam int ENTRY_W      = 24;
  localparam int ADDR_W       = 18;
  localparam int PAGE_W       = 8;
  localparam int GAP_SHIFT    = 5;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int SLOT_W       = $clog2(RECORDS_PER_PAGE + 1);
  localparam int FILL_W       = $clog2(ENTRIES_PER_RECORD + 1);
  localparam int ENTRY_IDX_W  = (ENTRIES_PER_RECORD > 1) ? $clog2(ENTRIES_PER_RECORD) : 1;
  localparam int OFF_W        = $clog2(RECORD_STRIDE);

  localparam logic [7:0] MAGIC_LO = 8'h52;
  localparam logic [7:0] MAGIC_HI = 8'h44;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_PAGE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_PAGE = 2'd2;

  typedef struct packed {
    logic               time_valid;
    logic [31:0]        timestamp;
    logic signed [15:0] temperature;
    logic signed [7:0]  signal_strength;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] flash_addr;
    logic [7:0]        data_byte;
    logic              erase_req;
    logic [PAGE_W-1:0] erase_page;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic open_rec;
    logic add_entry;
    logic upd_prev;
    logic flush_start;
    logic byte_load;
    logic finish;
    logic reopen;
  } tdrp_cmd_t;

  typedef struct packed {
    logic sample_valid;
    logic rec_open;
    logic gap;
    logic full_after;
    logic byte_last;
    logic out_free;
  } tdrp_sts_t;

  function automatic logic [PAGE_W-1:0] ring_next(input logic [PAGE_W-1:0] p,
                                                  input logic [PAGE_W-1:0] first,
                                                  input logic [PAGE_W-1:0] last_pg);
    logic [PAGE_W-1:0] r;
    if (p >= last_pg) begin
      r = first;
    end else begin
      r = p + PAGE_W'(1);
    end
    return r;
  endfunction

endpackage

/* rtl/tdrp_ctrl.sv */
// ----------------------------------------------------------------------------
// tdrp_ctrl
// Sequencer: takes a sample, evaluates it, and drives the record flush.
// ----------------------------------------------------------------------------
module tdrp_ctrl import tdrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tdrp_sts_t sts,
  output tdrp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       reopen_r, reopen_nxt;

  always_comb begin
    state_nxt  = state_r;
    reopen_nxt = reopen_r;
    cmd        = '0;
    cmd.reopen = reopen_r;
    in_ready   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_nxt = ST_IDLE;
        if (sts.sample_valid) begin
          cmd.upd_prev = 1'b1;
          if (!sts.rec_open) begin
            cmd.open_rec = 1'b1;
          end else if (sts.gap) begin
            reopen_nxt = 1'b1;
            state_nxt  = ST_START;
          end else begin
            cmd.add_entry = 1'b1;
            if (sts.full_after) begin
              reopen_nxt = 1'b0;
              state_nxt  = ST_START;
            end
          end
        end
      end
      ST_START: begin
        cmd.flush_start = 1'b1;
        state_nxt       = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.byte_load = 1'b1;
          if (sts.byte_last) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      reopen_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      reopen_r <= reopen_nxt;
    end
  end

endmodule

/* rtl/tdrp_datapath.sv */
// ----------------------------------------------------------------------------
// tdrp_datapath
// Record state, entry store, page ring and the byte output register.
// ----------------------------------------------------------------------------
module tdrp_datapath import tdrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  tdrp_cmd_t            cmd,
  output tdrp_sts_t            sts
);

  in_item_t            sample_r;
  logic [31:0]         header_time_r;
  logic [15:0]         base_temp_r;
  logic [7:0]          header_rssi_r;
  logic [ENTRY_W-1:0]  entry_r [ENTRIES_PER_RECORD];
  logic [FILL_W-1:0]   fill_r;
  logic                rec_open_r;
  logic [31:0]         prev_time_r;
  logic [15:0]         prev_temp_r;
  logic [PAGE_W-1:0]   first_page_r, last_page_r;
  logic [PAGE_W-1:0]   write_page_r;
  logic [SLOT_W-1:0]   write_slot_r;
  logic                erase_r;
  logic [PAGE_W-1:0]   erase_pg_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [OFF_W-1:0]    off_r, e_r;
  logic [1:0]          b_r;
  logic                out_valid_r;
  out_item_t           out_data_r;

  logic [31:0]         dt;
  logic [15:0]         temp_u;
  logic [15:0]         dtemp;
  logic [ENTRY_W-1:0]  entry_new;
  logic [FILL_W:0]     fill_inc;
  logic [SLOT_W-1:0]   slot_inc;
  logic [PAGE_W-1:0]   page_adv;
  logic [ADDR_W-1:0]   base_addr;
  logic [ENTRY_W-1:0]  entry_rd;
  logic [7:0]          byte_val;
  logic                byte_last;

  assign dt        = sample_r.timestamp - prev_time_r;
  assign temp_u    = sample_r.temperature;
  assign dtemp     = temp_u - prev_temp_r;
  assign entry_new = {dt[4:0], dtemp[10:8], dtemp[7:0], sample_r.signal_strength};
  assign fill_inc  = {1'b0, fill_r} + (FILL_W+1)'(1);
  assign slot_inc  = write_slot_r + SLOT_W'(1);
  assign page_adv  = ring_next(write_page_r, first_page_r, last_page_r);
  assign base_addr = (ADDR_W'(write_page_r) << PAGE_SHIFT)
                   + ADDR_W'(write_slot_r) * ADDR_W'(RECORD_STRIDE);
  assign entry_rd  = entry_r[e_r[ENTRY_IDX_W-1:0]];
  assign byte_last = (off_r == OFF_W'(RECORD_STRIDE - 1));

  always_comb begin
    byte_val = 8'h00;
    if (32'(off_r) < 32'(HEADER_BYTES)) begin
      case (off_r[2:0])
        3'd0:    byte_val = header_time_r[7:0];
        3'd1:    byte_val = header_time_r[15:8];
        3'd2:    byte_val = header_time_r[23:16];
        3'd3:    byte_val = header_time_r[31:24];
        3'd4:    byte_val = base_temp_r[7:0];
        3'd5:    byte_val = base_temp_r[15:8];
        3'd6:    byte_val = header_rssi_r;
        default: byte_val = 8'h00;
      endcase
    end else if (off_r == OFF_W'(RECORD_STRIDE - 2)) begin
      byte_val = MAGIC_LO;
    end else if (byte_last) begin
      byte_val = MAGIC_HI;
    end else if (32'(e_r) < 32'(ENTRIES_PER_RECORD)) begin
      case (b_r)
        2'd0:    byte_val = entry_rd[23:16];
        2'd1:    byte_val = entry_rd[15:8];
        default: byte_val = entry_rd[7:0];
      endcase
    end
  end

  always_comb begin
    sts.sample_valid = sample_r.time_valid;
    sts.rec_open     = rec_open_r;
    sts.gap          = |dt[31:GAP_SHIFT];
    sts.full_after   = (fill_inc >= (FILL_W+1)'(ENTRIES_PER_RECORD));
    sts.byte_last    = byte_last;
    sts.out_free     = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_time_r <= '0;
      base_temp_r   <= '0;
      header_rssi_r <= '0;
      fill_r        <= '0;
      rec_open_r    <= 1'b0;
      prev_time_r   <= '0;
      prev_temp_r   <= '0;
      for (int i = 0; i < ENTRIES_PER_RECORD; i++) begin
        entry_r[i] <= '0;
      end
    end else begin
      if (cmd.upd_prev) begin
        prev_time_r <= sample_r.timestamp;
        prev_temp_r <= temp_u;
      end
      if (cmd.add_entry) begin
        if (fill_inc <= (FILL_W+1)'(ENTRIES_PER_RECORD)) begin
          entry_r[fill_r[ENTRY_IDX_W-1:0]] <= entry_new;
        end
        fill_r <= fill_inc[FILL_W-1:0];
      end
      if (cmd.open_rec || (cmd.finish && cmd.reopen)) begin
        header_time_r <= sample_r.timestamp;
        base_temp_r   <= temp_u;
        header_rssi_r <= sample_r.signal_strength;
        fill_r        <= '0;
        rec_open_r    <= 1'b1;
      end else if (cmd.finish) begin
        fill_r     <= '0;
        rec_open_r <= 1'b0;
      end
      if (cmd.finish) begin
        for (int i = 0; i < ENTRIES_PER_RECORD; i++) begin
          entry_r[i] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_page_r <= '0;
      last_page_r  <= '1;
      write_page_r <= '0;
      write_slot_r <= '0;
      erase_r      <= 1'b0;
      erase_pg_r   <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_FIRST_PAGE: first_page_r <= cfg_data;
          CFG_LAST_PAGE:  last_page_r  <= cfg_data;
          CFG_START_PAGE: begin
            write_page_r <= cfg_data;
            write_slot_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.flush_start) begin
        if (32'(slot_inc) >= 32'(RECORDS_PER_PAGE)) begin
          write_page_r <= page_adv;
          erase_pg_r   <= ring_next(page_adv, first_page_r, last_page_r);
          erase_r      <= 1'b1;
          write_slot_r <= '0;
        end else begin
          write_slot_r <= slot_inc;
          erase_r      <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
      off_r  <= '0;
      e_r    <= '0;
      b_r    <= '0;
    end else if (cmd.flush_start) begin
      addr_r <= base_addr;
      off_r  <= '0;
      e_r    <= '0;
      b_r    <= '0;
    end else if (cmd.byte_load) begin
      addr_r <= addr_r + ADDR_W'(1);
      off_r  <= off_r + OFF_W'(1);
      if (32'(off_r) >= 32'(HEADER_BYTES)) begin
        if (b_r == 2'd2) begin
          b_r <= '0;
          e_r <= e_r + OFF_W'(1);
        end else begin
          b_r <= b_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.byte_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_load) begin
      out_data_r.flash_addr <= addr_r;
      out_data_r.data_byte  <= byte_val;
      out_data_r.erase_req  <= byte_last && erase_r;
      out_data_r.erase_page <= (byte_last && erase_r) ? erase_pg_r : '0;
      out_data_r.last       <= byte_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/temperature_delta_record_packer_top.sv */
// ----------------------------------------------------------------------------
// temperature_delta_record_packer_top
// Packs timestamped temperature samples into flash records and streams each
// finished record as addressed bytes.
//
//   channel  direction  handshake                    payload
//   in_      input      in_valid / in_ready          in_item_t
//   out_     output     out_valid / out_ready        out_item_t, one record byte
//   cfg_     input      cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A sample that causes no record passes through the capture and evaluate states.
// A sample that closes a record adds a setup state and one beat per record
// byte (RECORD_STRIDE beats) through the single output register.
// Output stalls hold the flush; the next sample is taken while the last
// beat still waits. Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module temperature_delta_record_packer_top import tdrp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  tdrp_cmd_t cmd;
  tdrp_sts_t sts;

  assign cfg_ready = 1'b1;

  tdrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tdrp_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
